>>> rtl/lbs_pkg.sv
// lbs_pkg: shared types and codes of the link bring-up sequencer
// state, action and register codes, configuration, item, context and result structs
// no dependencies
`default_nettype none

package lbs_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned S_TDATA_W   = 72;
	localparam int unsigned M_TDATA_W   = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INITIAL_WAIT   = 3'd0,
		REG_RECONNECT_WAIT = 3'd1,
		REG_TIME_WAIT      = 3'd2,
		REG_BROKER_WAIT    = 3'd3,
		REG_MAX_FAILURES   = 3'd4,
		REG_ANNOUNCE_INTV  = 3'd5
	} lbs_reg_t;

	typedef enum logic [3:0] {
		ST_INIT         = 4'd0,
		ST_CONNECTING   = 4'd1,
		ST_LINK_UP      = 4'd2,
		ST_REQ_TIME     = 4'd3,
		ST_SETTING_TIME = 4'd4,
		ST_FIRMWARE     = 4'd5,
		ST_LINK_READY   = 4'd6,
		ST_BROKER_CONN  = 4'd7,
		ST_BROKER_WAIT  = 4'd8,
		ST_BROKER_UP    = 4'd9,
		ST_READY        = 4'd10,
		ST_DISCONNECTED = 4'd11
	} lbs_state_t;

	typedef enum logic [3:0] {
		ACT_NONE         = 4'd0,
		ACT_RESTART      = 4'd1,
		ACT_RECONNECT    = 4'd2,
		ACT_LINK_READY   = 4'd3,
		ACT_REQ_TIME     = 4'd4,
		ACT_FIRMWARE     = 4'd5,
		ACT_BROKER_BEGIN = 4'd6,
		ACT_BROKER_READY = 4'd7,
		ACT_SERVICE      = 4'd8
	} lbs_action_t;

	localparam logic [31:0] INITIAL_WAIT_RST   = 32'd10000000;
	localparam logic [31:0] RECONNECT_WAIT_RST = 32'd5000000;
	localparam logic [31:0] TIME_WAIT_RST      = 32'd10000000;
	localparam logic [31:0] BROKER_WAIT_RST    = 32'd2000000;
	localparam logic [7:0]  MAX_FAILURES_RST   = 8'd5;
	localparam logic [31:0] ANNOUNCE_INTV_RST  = 32'(3600 * 1000);

	typedef struct packed {
		logic [31:0] initial_wait_us;
		logic [31:0] reconnect_wait_us;
		logic [31:0] time_wait_us;
		logic [31:0] broker_wait_us;
		logic [7:0]  max_failures;
		logic [31:0] announce_interval_ms;
	} lbs_cfg_t;

	typedef struct packed {
		logic        command;
		logic [31:0] now_us;
		logic [31:0] now_ms;
		logic        link_connected;
		logic        link_needs_reinit;
		logic        broker_connected;
		logic        time_set;
	} lbs_item_t;

	typedef struct packed {
		lbs_state_t  st;
		logic        use_reconnect_wait;
		logic [7:0]  failure_count;
		logic [31:0] link_start_us;
		logic [31:0] time_request_us;
		logic [31:0] broker_start_us;
		logic [31:0] last_announce_ms;
	} lbs_ctx_t;

	typedef struct packed {
		logic [3:0]  link_state;
		lbs_action_t action;
		logic        publish_announcements;
	} lbs_result_t;

endpackage

`default_nettype wire

>>> rtl/lbs_cfg_regs.sv
// lbs_cfg_regs: configuration register file of the sequencer
// plain write port, no read-back; uses lbs_pkg
`default_nettype none

module lbs_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output lbs_pkg::lbs_cfg_t                    cfg
);
	import lbs_pkg::*;

	lbs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_wait_us      <= INITIAL_WAIT_RST;
			cfg_q.reconnect_wait_us    <= RECONNECT_WAIT_RST;
			cfg_q.time_wait_us         <= TIME_WAIT_RST;
			cfg_q.broker_wait_us       <= BROKER_WAIT_RST;
			cfg_q.max_failures         <= MAX_FAILURES_RST;
			cfg_q.announce_interval_ms <= ANNOUNCE_INTV_RST;
		end else if (cfg_we) begin
			case (lbs_reg_t'(cfg_index))
				REG_INITIAL_WAIT:   cfg_q.initial_wait_us      <= cfg_wdata;
				REG_RECONNECT_WAIT: cfg_q.reconnect_wait_us    <= cfg_wdata;
				REG_TIME_WAIT:      cfg_q.time_wait_us         <= cfg_wdata;
				REG_BROKER_WAIT:    cfg_q.broker_wait_us       <= cfg_wdata;
				REG_MAX_FAILURES:   cfg_q.max_failures         <= cfg_wdata[7:0];
				REG_ANNOUNCE_INTV:  cfg_q.announce_interval_ms <= cfg_wdata;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/lbs_step.sv
// lbs_step: next-state and action logic for one poll item
// purely combinational; uses lbs_pkg
`default_nettype none

module lbs_step (
	input  wire lbs_pkg::lbs_cfg_t    cfg,
	input  wire lbs_pkg::lbs_item_t   item,
	input  wire lbs_pkg::lbs_ctx_t    ctx,
	output lbs_pkg::lbs_ctx_t         ctx_nxt,
	output lbs_pkg::lbs_result_t      res
);
	import lbs_pkg::*;

	logic [31:0] link_elapsed;
	logic [31:0] time_elapsed;
	logic [31:0] broker_elapsed;
	logic [31:0] announce_elapsed;
	logic [31:0] link_limit;
	logic [8:0]  fail_inc;
	logic        publish;
	lbs_action_t action;

	assign link_elapsed     = item.now_us - ctx.link_start_us;
	assign time_elapsed     = item.now_us - ctx.time_request_us;
	assign broker_elapsed   = item.now_us - ctx.broker_start_us;
	assign announce_elapsed = item.now_ms - ctx.last_announce_ms;
	assign link_limit       = ctx.use_reconnect_wait ? cfg.reconnect_wait_us
	                                                 : cfg.initial_wait_us;
	// one bit wider so a limit of 255 still trips
	assign fail_inc         = {1'b0, ctx.failure_count} + 9'd1;

	always_comb begin
		ctx_nxt = ctx;
		action  = ACT_NONE;
		publish = 1'b0;
		if (item.command) begin
			ctx_nxt.st                 = ST_INIT;
			ctx_nxt.use_reconnect_wait = 1'b0;
			ctx_nxt.failure_count      = '0;
		end else begin
			case (ctx.st)
				ST_CONNECTING: begin
					if (item.link_connected) begin
						ctx_nxt.st            = ST_LINK_UP;
						ctx_nxt.failure_count = '0;
						action                = ACT_LINK_READY;
					end else if (link_elapsed > link_limit) begin
						if (fail_inc > {1'b0, cfg.max_failures}) begin
							ctx_nxt.st            = ST_INIT;
							ctx_nxt.failure_count = '0;
						end else begin
							ctx_nxt.st            = ST_DISCONNECTED;
							ctx_nxt.failure_count = fail_inc[7:0];
						end
					end
				end
				ST_LINK_UP: begin
					if (item.link_needs_reinit) begin
						ctx_nxt.st = ST_INIT;
					end else if (!item.link_connected) begin
						ctx_nxt.st = ST_DISCONNECTED;
					end else begin
						ctx_nxt.st            = ST_REQ_TIME;
						ctx_nxt.failure_count = '0;
					end
				end
				ST_REQ_TIME: begin
					if (item.time_set) begin
						ctx_nxt.st = ST_FIRMWARE;
					end else begin
						ctx_nxt.st              = ST_SETTING_TIME;
						ctx_nxt.time_request_us = item.now_us;
						action                  = ACT_REQ_TIME;
					end
				end
				ST_SETTING_TIME: begin
					if (!item.link_connected) begin
						ctx_nxt.st = ST_DISCONNECTED;
					end else if (item.time_set) begin
						ctx_nxt.st = ST_FIRMWARE;
					end else if (time_elapsed > cfg.time_wait_us) begin
						ctx_nxt.st = ST_LINK_UP;
					end
				end
				ST_FIRMWARE: begin
					ctx_nxt.st = ST_LINK_READY;
					action     = ACT_FIRMWARE;
				end
				ST_LINK_READY: begin
					if (item.link_connected) begin
						ctx_nxt.st              = ST_BROKER_CONN;
						ctx_nxt.broker_start_us = item.now_us;
						action                  = ACT_BROKER_BEGIN;
					end else begin
						ctx_nxt.st = ST_DISCONNECTED;
					end
				end
				ST_BROKER_CONN: begin
					ctx_nxt.st = item.broker_connected ? ST_BROKER_UP : ST_BROKER_WAIT;
				end
				ST_BROKER_WAIT: begin
					if (broker_elapsed >= cfg.broker_wait_us) begin
						ctx_nxt.st = ST_LINK_READY;
					end
				end
				ST_BROKER_UP: begin
					if (!item.broker_connected) begin
						ctx_nxt.st = ST_LINK_READY;
					end else begin
						// a zero stamp reads as never announced
						if ((ctx.last_announce_ms == 32'd0) ||
						    (announce_elapsed > cfg.announce_interval_ms)) begin
							publish                  = 1'b1;
							ctx_nxt.last_announce_ms = item.now_ms;
						end
						ctx_nxt.st = ST_READY;
						action     = ACT_BROKER_READY;
					end
				end
				ST_READY: begin
					if (!item.link_connected) begin
						ctx_nxt.st = ST_DISCONNECTED;
					end else if (!item.broker_connected) begin
						ctx_nxt.st = ST_LINK_READY;
					end else begin
						action = ACT_SERVICE;
					end
				end
				ST_DISCONNECTED: begin
					// link start stamp deliberately kept from the last restart
					ctx_nxt.st                 = ST_CONNECTING;
					ctx_nxt.use_reconnect_wait = 1'b1;
					action                     = ACT_RECONNECT;
				end
				default: begin
					// init and unused codes: full restart
					ctx_nxt.st                 = ST_CONNECTING;
					ctx_nxt.use_reconnect_wait = 1'b0;
					ctx_nxt.link_start_us      = item.now_us;
					action                     = ACT_RESTART;
				end
			endcase
		end
	end

	assign res.link_state            = 4'(ctx_nxt.st);
	assign res.action                = action;
	assign res.publish_announcements = publish;

endmodule

`default_nettype wire

>>> rtl/link_bringup_sequencer_top.sv
// link_bringup_sequencer_top: top level of the link bring-up sequencer
// a poll transfer passes the input register, then the result register,
// before its result transfer goes out; an output stall holds both
// one poll per cycle while the output is not stalled; the state loop closes
// through lbs_step; reset clears state to init, configuration to defaults
// depends on lbs_pkg, lbs_cfg_regs, lbs_step
`default_nettype none

module link_bringup_sequencer_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [lbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// poll item stream
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// s_tdata from bit 0: now_us[31:0], now_ms[63:32], link_connected[64],
	// link_needs_reinit[65], broker_connected[66], time_set[67], zero pad
	input  wire logic [lbs_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: command[0]
	input  wire logic                            s_tuser,
	// result stream
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata from bit 0: link_state[3:0], action[7:4],
	// publish_announcements[8], zero pad
	output      logic [lbs_pkg::M_TDATA_W-1:0]   m_tdata
);
	import lbs_pkg::*;

	lbs_cfg_t    cfg;
	lbs_item_t   item_in;
	lbs_item_t   item_s1;
	logic        valid_s1;
	lbs_ctx_t    ctx_q;
	lbs_ctx_t    ctx_nxt;
	lbs_result_t res_nxt;
	lbs_result_t res_s2;
	logic        valid_s2;
	logic        out_free;
	logic        step_fire;
	logic        in_xfer;

	lbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// unpack the incoming transfer
	always_comb begin
		item_in.command           = s_tuser;
		item_in.now_us            = s_tdata[31:0];
		item_in.now_ms            = s_tdata[63:32];
		item_in.link_connected    = s_tdata[64];
		item_in.link_needs_reinit = s_tdata[65];
		item_in.broker_connected  = s_tdata[66];
		item_in.time_set          = s_tdata[67];
	end

	// the result register can take a new result when empty or being drained
	assign out_free  = !valid_s2 || m_tready;
	// the registered item is stepped when its result has a place to go
	assign step_fire = valid_s1 && out_free;
	// input register refills as soon as its item moves on
	assign s_tready  = !valid_s1 || out_free;
	assign in_xfer   = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item_in;
		end
	end

	lbs_step u_step (
		.cfg     (cfg),
		.item    (item_s1),
		.ctx     (ctx_q),
		.ctx_nxt (ctx_nxt),
		.res     (res_nxt)
	);

	// sequencer context: advances once per stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.st                 <= ST_INIT;
			ctx_q.use_reconnect_wait <= 1'b0;
			ctx_q.failure_count      <= '0;
			ctx_q.link_start_us      <= '0;
			ctx_q.time_request_us    <= '0;
			ctx_q.broker_start_us    <= '0;
			ctx_q.last_announce_ms   <= '0;
		end else if (step_fire) begin
			ctx_q <= ctx_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.publish_announcements, 4'(res_s2.action),
	                   res_s2.link_state};

	// begin command always lands in init with no action and no burst
	a_begin_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire && item_s1.command |=>
			(res_s2.link_state == 4'(ST_INIT)) && (res_s2.action == ACT_NONE) &&
			!res_s2.publish_announcements)
		else $error("begin command did not yield init result");

	// an announcement burst only comes with the broker-ready step
	a_publish_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.publish_announcements |->
			(res_s2.action == ACT_BROKER_READY) &&
			(res_s2.link_state == 4'(ST_READY)))
		else $error("announcement burst outside broker-ready step");

	// context holds while no item is stepped
	a_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_fire |=> $stable(ctx_q))
		else $error("sequencer context changed without a stepped item");

	// a held item stays registered until its result can be stored
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("registered item lost while result side stalled");

endmodule

`default_nettype wire

>>> dv/lbs_checker.sv
// lbs_checker: predicts and checks the result stream of the link bring-up sequencer
// mirrors configuration and state from the register writes and poll transfers it sees
// depends on lbs_pkg
module lbs_checker
	import lbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// s_tdata from bit 0: now_us, now_ms, link_connected, link_needs_reinit,
	// broker_connected, time_set, zero pad
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// s_tuser: command
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata from bit 0: link_state, action, publish_announcements, zero pad
	input  logic [M_TDATA_W-1:0]   m_tdata,
	output int unsigned            mismatches,
	output int unsigned            results_seen,
	output int unsigned            awaiting
);

	lbs_cfg_t    regs;
	lbs_state_t  seq_state;
	logic        reconnect_mode;
	logic [7:0]  fail_tally;
	logic [31:0] link_t0_us;
	logic [31:0] time_req_us;
	logic [31:0] broker_t0_us;
	logic [31:0] announce_ms;
	lbs_result_t poll_replies[$];

	// one poll: at most one transition, one action code
	task automatic advance_sequencer(input lbs_item_t it, output lbs_result_t res);
		logic [8:0]  tally_next;
		logic [31:0] limit_us;
		lbs_action_t act;
		logic        pub;
		act = ACT_NONE;
		pub = 1'b0;
		if (it.command) begin
			seq_state = ST_INIT;
			reconnect_mode = 1'b0;
			fail_tally = 8'd0;
		end else begin
			case (seq_state)
				ST_CONNECTING: begin
					limit_us = reconnect_mode ? regs.reconnect_wait_us : regs.initial_wait_us;
					if (it.link_connected) begin
						seq_state = ST_LINK_UP;
						fail_tally = 8'd0;
						act = ACT_LINK_READY;
					end else if (32'(it.now_us - link_t0_us) > limit_us) begin
						// counted one bit wider so a limit of 255 still restarts
						tally_next = {1'b0, fail_tally} + 9'd1;
						if (tally_next > {1'b0, regs.max_failures}) begin
							seq_state = ST_INIT;
							fail_tally = 8'd0;
						end else begin
							fail_tally = tally_next[7:0];
							seq_state = ST_DISCONNECTED;
						end
					end
				end
				ST_LINK_UP: begin
					if (it.link_needs_reinit) begin
						seq_state = ST_INIT;
					end else if (!it.link_connected) begin
						seq_state = ST_DISCONNECTED;
					end else begin
						seq_state = ST_REQ_TIME;
						fail_tally = 8'd0;
					end
				end
				ST_REQ_TIME: begin
					if (it.time_set) begin
						seq_state = ST_FIRMWARE;
					end else begin
						seq_state = ST_SETTING_TIME;
						time_req_us = it.now_us;
						act = ACT_REQ_TIME;
					end
				end
				ST_SETTING_TIME: begin
					if (!it.link_connected)
						seq_state = ST_DISCONNECTED;
					else if (it.time_set)
						seq_state = ST_FIRMWARE;
					else if (32'(it.now_us - time_req_us) > regs.time_wait_us)
						seq_state = ST_LINK_UP;
				end
				ST_FIRMWARE: begin
					seq_state = ST_LINK_READY;
					act = ACT_FIRMWARE;
				end
				ST_LINK_READY: begin
					if (it.link_connected) begin
						seq_state = ST_BROKER_CONN;
						broker_t0_us = it.now_us;
						act = ACT_BROKER_BEGIN;
					end else begin
						seq_state = ST_DISCONNECTED;
					end
				end
				ST_BROKER_CONN: begin
					if (it.broker_connected)
						seq_state = ST_BROKER_UP;
					else
						seq_state = ST_BROKER_WAIT;
				end
				ST_BROKER_WAIT: begin
					if (32'(it.now_us - broker_t0_us) >= regs.broker_wait_us)
						seq_state = ST_LINK_READY;
				end
				ST_BROKER_UP: begin
					if (!it.broker_connected) begin
						seq_state = ST_LINK_READY;
					end else begin
						// a zero stamp reads as never announced
						if (announce_ms == 32'd0 ||
								32'(it.now_ms - announce_ms) > regs.announce_interval_ms) begin
							pub = 1'b1;
							announce_ms = it.now_ms;
						end
						seq_state = ST_READY;
						act = ACT_BROKER_READY;
					end
				end
				ST_READY: begin
					if (!it.link_connected)
						seq_state = ST_DISCONNECTED;
					else if (!it.broker_connected)
						seq_state = ST_LINK_READY;
					else
						act = ACT_SERVICE;
				end
				ST_DISCONNECTED: begin
					// link start time stays from the last full restart
					seq_state = ST_CONNECTING;
					reconnect_mode = 1'b1;
					act = ACT_RECONNECT;
				end
				default: begin
					seq_state = ST_CONNECTING;
					reconnect_mode = 1'b0;
					link_t0_us = it.now_us;
					act = ACT_RESTART;
				end
			endcase
		end
		res.link_state = seq_state;
		res.action = act;
		res.publish_announcements = pub;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lbs_item_t   it;
		lbs_result_t want;
		if (!arst_n) begin
			regs.initial_wait_us = INITIAL_WAIT_RST;
			regs.reconnect_wait_us = RECONNECT_WAIT_RST;
			regs.time_wait_us = TIME_WAIT_RST;
			regs.broker_wait_us = BROKER_WAIT_RST;
			regs.max_failures = MAX_FAILURES_RST;
			regs.announce_interval_ms = ANNOUNCE_INTV_RST;
			seq_state = ST_INIT;
			reconnect_mode = 1'b0;
			fail_tally = 8'd0;
			link_t0_us = 32'd0;
			time_req_us = 32'd0;
			broker_t0_us = 32'd0;
			announce_ms = 32'd0;
			poll_replies.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INITIAL_WAIT:   regs.initial_wait_us = cfg_wdata;
					REG_RECONNECT_WAIT: regs.reconnect_wait_us = cfg_wdata;
					REG_TIME_WAIT:      regs.time_wait_us = cfg_wdata;
					REG_BROKER_WAIT:    regs.broker_wait_us = cfg_wdata;
					REG_MAX_FAILURES:   regs.max_failures = cfg_wdata[7:0];
					REG_ANNOUNCE_INTV:  regs.announce_interval_ms = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it.command = s_tuser;
				it.now_us = s_tdata[31:0];
				it.now_ms = s_tdata[63:32];
				it.link_connected = s_tdata[64];
				it.link_needs_reinit = s_tdata[65];
				it.broker_connected = s_tdata[66];
				it.time_set = s_tdata[67];
				advance_sequencer(it, want);
				poll_replies.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (poll_replies.size() == 0) begin
					$error("result transfer with no poll outstanding: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = poll_replies.pop_front();
					if (m_tdata[3:0] !== want.link_state) begin
						$error("link_state: expected %0d, got %0d", want.link_state, m_tdata[3:0]);
						mismatches++;
					end
					if (m_tdata[7:4] !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, m_tdata[7:4]);
						mismatches++;
					end
					if (m_tdata[8] !== want.publish_announcements) begin
						$error("publish_announcements: expected %0d, got %0d",
							want.publish_announcements, m_tdata[8]);
						mismatches++;
					end
				end
			end
		end
		awaiting = poll_replies.size();
	end

endmodule

>>> dv/tb.sv
// tb: stimulus and verdict for link_bringup_sequencer_top
// drives polls and register writes, checking is done by lbs_checker
// depends on lbs_pkg, lbs_checker and the rtl top level
module tb;
	import lbs_pkg::*;

	// cycles with no transfer on either side before the run is abandoned
	localparam int unsigned QUIET_LIMIT = 1000;

	// register settings applied per phase
	typedef enum int {
		SET_SMALL,
		SET_ZERO,
		SET_FULL,
		SET_SCATTER,
		SET_STORM,
		SET_DEFAULT
	} setting_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tready = 1'b0;
	wire                    s_tready;
	wire                    m_tvalid;
	wire  [M_TDATA_W-1:0]   m_tdata;

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned awaiting;

	// idling on both sides, switched off for the last phase
	bit          bursts_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned polls_sent = 0;
	int unsigned settings_loaded = 0;
	// time stamps carried into the poll items, stepped per poll
	logic [31:0] clk_us = 32'd0;
	logic [31:0] clk_ms = 32'd0;

	always #1 clk = ~clk;

	link_bringup_sequencer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	lbs_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.awaiting     (awaiting)
	);

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (bursts_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// one poll transfer, optionally after a sender gap; returns at the accepting edge
	task poll(input logic cmd, input logic [31:0] us, input logic [31:0] ms,
			input logic lk, input logic ri, input logic bk, input logic ts);
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0000, ts, bk, ri, lk, ms, us};
		do @(posedge clk); while (!s_tready);
		polls_sent++;
	endtask

	// mostly small steps so timer limits are hit exactly, sometimes long jumps
	function automatic logic [31:0] bump(input logic [31:0] t);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return t + $urandom_range(0, 6);
		else if (pick < 85)
			return t + $urandom_range(0, 40);
		else if (pick < 95)
			return t + $urandom;
		return $urandom;
	endfunction

	// mostly plausible flag patterns so the machine gets to ready, some noise
	task random_poll;
		clk_us = bump(clk_us);
		clk_ms = bump(clk_ms);
		if ($urandom_range(0, 99) < 15)
			poll($urandom_range(0, 3) == 0, clk_us, clk_ms, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else
			poll($urandom_range(0, 99) == 0, clk_us, clk_ms, $urandom_range(0, 9) != 0,
				$urandom_range(0, 24) == 0, $urandom_range(0, 4) != 0,
				1'($urandom_range(0, 1)));
	endtask

	task put_reg(input lbs_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// writes all six registers, only called with nothing in flight
	task load_settings(input setting_kind_t kind);
		logic [31:0] w_init, w_reconn, w_time, w_broker, w_ann;
		logic [7:0]  w_max;
		case (kind)
			SET_SMALL: begin
				w_init = $urandom_range(0, 12);
				w_reconn = $urandom_range(0, 12);
				w_time = $urandom_range(0, 12);
				w_broker = $urandom_range(0, 12);
				w_max = 8'($urandom_range(0, 4));
				w_ann = $urandom_range(0, 40);
			end
			SET_ZERO: begin
				w_init = '0;
				w_reconn = '0;
				w_time = '0;
				w_broker = '0;
				w_max = '0;
				w_ann = '0;
			end
			SET_FULL: begin
				w_init = '1;
				w_reconn = '1;
				w_time = '1;
				w_broker = '1;
				w_max = '1;
				w_ann = '1;
			end
			SET_SCATTER: begin
				w_init = $urandom;
				w_reconn = $urandom;
				w_time = $urandom;
				w_broker = $urandom;
				w_max = 8'($urandom_range(0, 255));
				w_ann = $urandom;
			end
			SET_STORM: begin
				// instant link timeouts, failure limit at its top
				w_init = '0;
				w_reconn = '0;
				w_time = $urandom_range(0, 12);
				w_broker = $urandom_range(0, 12);
				w_max = 8'hFF;
				w_ann = $urandom_range(0, 40);
			end
			default: begin
				w_init = INITIAL_WAIT_RST;
				w_reconn = RECONNECT_WAIT_RST;
				w_time = TIME_WAIT_RST;
				w_broker = BROKER_WAIT_RST;
				w_max = MAX_FAILURES_RST;
				w_ann = ANNOUNCE_INTV_RST;
			end
		endcase
		put_reg(REG_INITIAL_WAIT, w_init);
		put_reg(REG_RECONNECT_WAIT, w_reconn);
		put_reg(REG_TIME_WAIT, w_time);
		put_reg(REG_BROKER_WAIT, w_broker);
		put_reg(REG_MAX_FAILURES, {24'd0, w_max});
		put_reg(REG_ANNOUNCE_INTV, w_ann);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	// stop sending, wait for every outstanding result, then the pipeline latency
	task drain;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		setting_kind_t plan [8];
		plan = '{SET_SMALL, SET_SCATTER, SET_ZERO, SET_STORM, SET_FULL, SET_SMALL,
			SET_DEFAULT, SET_SMALL};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk at reset settings
		poll(1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);                // init, restart at 0
		poll(1'b0, 32'd10000000, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0);         // link timeout: equal, holds
		poll(1'b0, 32'd10000001, 32'd2, 1'b0, 1'b0, 1'b0, 1'b0);         // one past, disconnected
		poll(1'b0, 32'd10000001, 32'd3, 1'b0, 1'b0, 1'b0, 1'b0);         // reconnect
		poll(1'b0, 32'd10000001, 32'd4, 1'b0, 1'b0, 1'b0, 1'b0);         // reconnect limit, old start
		poll(1'b0, 32'd10000002, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0);         // reconnect
		poll(1'b0, 32'd10000003, 32'd6, 1'b1, 1'b0, 1'b0, 1'b0);         // link up
		poll(1'b0, 32'd10000004, 32'd7, 1'b1, 1'b1, 1'b0, 1'b0);         // reinit request
		poll(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1); // restart at top of range
		poll(1'b0, 32'd5, 32'd8, 1'b1, 1'b0, 1'b0, 1'b0);                // link up
		poll(1'b0, 32'd6, 32'd9, 1'b1, 1'b0, 1'b0, 1'b0);                // request time
		poll(1'b0, 32'd100, 32'd10, 1'b1, 1'b0, 1'b0, 1'b0);             // time request stamped
		poll(1'b0, 32'd10000100, 32'd11, 1'b1, 1'b0, 1'b0, 1'b0);        // time timeout: equal, holds
		poll(1'b0, 32'd10000101, 32'd12, 1'b1, 1'b0, 1'b0, 1'b0);        // one past, back to link up
		poll(1'b0, 32'd10000102, 32'd13, 1'b1, 1'b0, 1'b0, 1'b0);        // request time
		poll(1'b0, 32'd10000103, 32'd14, 1'b1, 1'b0, 1'b0, 1'b1);        // time already set
		poll(1'b0, 32'd10000104, 32'd15, 1'b1, 1'b0, 1'b0, 1'b0);        // firmware check
		poll(1'b0, 32'hFFFF_FFF0, 32'd16, 1'b1, 1'b0, 1'b0, 1'b0);       // broker begin near wrap
		poll(1'b0, 32'hFFFF_FFF8, 32'd17, 1'b1, 1'b0, 1'b0, 1'b0);       // broker absent, retry wait
		poll(1'b0, 32'd1999983, 32'd18, 1'b1, 1'b0, 1'b0, 1'b0);         // wrapped, one short
		poll(1'b0, 32'd1999984, 32'd19, 1'b1, 1'b0, 1'b0, 1'b0);         // retry fires on equal
		poll(1'b0, 32'd1999985, 32'd20, 1'b1, 1'b0, 1'b0, 1'b0);         // broker begin
		poll(1'b0, 32'd1999986, 32'd21, 1'b1, 1'b0, 1'b1, 1'b0);         // broker up
		poll(1'b0, 32'd1999987, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0);          // announce, stamp of zero
		poll(1'b0, 32'd1999988, 32'd22, 1'b1, 1'b0, 1'b1, 1'b0);         // service queues
		poll(1'b1, 32'd1999989, 32'd23, 1'b1, 1'b1, 1'b1, 1'b1);         // begin command
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				bursts_on <= 1'b0;
			load_settings(plan[p]);
			if (plan[p] == SET_STORM) begin
				// begin, then the link never comes up: 255 tolerated timeouts, the next restarts
				poll(1'b1, clk_us, clk_ms, 1'b0, 1'b0, 1'b0, 1'b0);
				repeat (530) begin
					clk_us = clk_us + 1;
					poll(1'b0, clk_us, $urandom, 1'b0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end else begin
				for (int n = 0; n < 105; n++) begin
					// sender holds off until the result side has caught up
					if (p == 5 && n == 50)
						drain();
					random_poll();
				end
			end
			drain();
		end

		$display("tb: %0d polls over %0d register settings, %0d results compared",
			polls_sent, settings_loaded, results_seen);
		$display("tb: timeouts at their edges, failure limit extremes, timers and announcements");
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
